/* rtl/core/iap_pkg.sv */
// Package for the 4x4 intra block predictor.
// Mode codes, neighbor availability masks and the request/result structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package iap_pkg;

    localparam int unsigned PIX_W = 8;

    localparam logic [3:0] AVAIL_TOP        = 4'd1;
    localparam logic [3:0] AVAIL_LEFT       = 4'd2;
    localparam logic [3:0] AVAIL_BELOW_LEFT = 4'd4;
    localparam logic [3:0] AVAIL_TOP_RIGHT  = 4'd8;

    localparam logic [PIX_W-1:0] FLAT_LEVEL = 8'd128;

    typedef enum logic [3:0] {
        MODE_DC        = 4'd0,
        MODE_VERT      = 4'd1,
        MODE_HORIZ     = 4'd2,
        MODE_DIAG_TR   = 4'd3,
        MODE_VERT_LEFT = 4'd4,
        MODE_VERT_RGT  = 4'd5,
        MODE_DOWN_RGT  = 4'd6,
        MODE_HORIZ_DN  = 4'd7,
        MODE_HORIZ_UP  = 4'd8,
        MODE_DIAG_BL   = 4'd9,
        MODE_FLAT      = 4'd10
    } mode_t;

    typedef struct packed {
        logic [3:0]  mode;
        logic [3:0]  avail;
        logic [63:0] top;
        logic [63:0] left;
        logic [7:0]  corner;
        logic [23:0] far_right;
        logic [7:0]  far_corner;
    } pred_req_t;

    typedef struct packed {
        logic              usable;
        logic [3:0][31:0]  rows;
    } pred_res_t;

endpackage

`default_nettype wire

/* rtl/core/iap_predict.sv */
// Combinational 4x4 prediction datapath: one request in, one result out.
// Depends on iap_pkg.
`timescale 1ns / 1ps
`default_nettype none

module iap_predict
    import iap_pkg::*;
(
    input  pred_req_t req,
    output pred_res_t res
);

    function automatic logic [7:0] avg2(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b} + 9'd1;
        return s[8:1];
    endfunction

    function automatic logic [10:0] w(input logic [7:0] v);
        return {3'b000, v};
    endfunction

    logic [7:0]  t [8];
    logic [7:0]  l [8];
    logic [7:0]  b [4][4];
    logic        ht, hl, hbl, htr, ok;
    logic [7:0]  tl, fc, f4, f5, f6;

    logic [10:0] dc_sum;
    logic [10:0] m3_s4, m3_s3, m3_s5;
    logic [10:0] m4_s5, m4_s4;
    logic [10:0] m5_sp, m5_s0, m5_s1;
    logic [10:0] m6_s0;
    logic [10:0] m7_s0, m7_sp, m7_s1;
    logic [10:0] m9_s4, m9_s5;
    logic [8:0]  m9_h26, m9_h37;

    logic [7:0]  dc, a3, a4, a5, v4a4, v4a5, m5x0, m5x1, m6x0, m7x0, m7x1, m9a4, m9a5;

    assign ht  = (req.avail & AVAIL_TOP) != 4'd0;
    assign hl  = (req.avail & AVAIL_LEFT) != 4'd0;
    assign hbl = (req.avail & AVAIL_BELOW_LEFT) != 4'd0;
    assign htr = (req.avail & AVAIL_TOP_RIGHT) != 4'd0;
    assign tl  = req.corner;
    assign fc  = req.far_corner;
    assign f4  = req.far_right[7:0];
    assign f5  = req.far_right[15:8];
    assign f6  = req.far_right[23:16];

    // Missing top-right / below-left repeat the last available pixel.
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            t[i] = req.top[8*i +: 8];
            l[i] = req.left[8*i +: 8];
        end
        if (!(ht && htr))
        begin
            for (int i = 4; i < 8; i++)
            begin
                t[i] = req.top[31:24];
            end
        end
        if (!(hl && hbl))
        begin
            for (int i = 4; i < 8; i++)
            begin
                l[i] = req.left[31:24];
            end
        end
    end

    always_comb
    begin
        dc_sum = 11'd4 + w(t[0]) + w(t[1]) + w(t[2]) + w(t[3])
                       + w(l[0]) + w(l[1]) + w(l[2]) + w(l[3]);

        m3_s4 = w(t[4]) * 11'd5 + w(f5) + 11'd4 + w(t[3]) + w(t[5]);
        m3_s3 = w(t[3]) * 11'd3 + w(f4) + 11'd2;
        m3_s5 = w(t[5]) * 11'd3 + w(f6) + 11'd2;

        m4_s5 = w(t[4]) + w(t[5]) * 11'd2 + w(t[6]) + 11'd2;
        m4_s4 = w(t[4]) * 11'd2 + w(t[5]) + w(t[3]) + 11'd2;

        m5_sp = w(t[0]) * 11'd3 + w(l[0]) + w(tl) * 11'd4 + 11'd4;
        m5_s0 = w(tl) * 11'd6 + w(t[0]) + w(l[0]) + 11'd4;
        m5_s1 = w(m5_sp[10:3]) * 11'd2 + w(m5_s0[10:3]) + w(t[0]) + 11'd2;

        m6_s0 = (w(t[0]) + w(l[0])) * 11'd2 + w(tl) * 11'd3 + 11'd4 + w(fc);

        m7_s0 = w(t[0]) + w(tl) * 11'd6 + w(l[0]) + 11'd4;
        m7_sp = w(l[0]) * 11'd4 + w(tl) * 11'd3 + w(t[0]) + 11'd4;
        m7_s1 = w(m7_s0[10:3]) + w(l[0]) + w(m7_sp[10:3]) * 11'd2 + 11'd2;

        m9_h26 = {1'b0, l[2]} + {1'b0, l[6]};
        m9_h37 = {1'b0, l[3]} + {1'b0, l[7]};
        m9_s4  = {3'b000, m9_h26[8:1]} + w(l[3]) + w(l[5]) + w(l[4]) * 11'd5 + 11'd4;
        m9_s5  = {3'b000, m9_h37[8:1]} + w(l[4]) + w(l[6]) + w(l[5]) * 11'd5 + 11'd4;
    end

    assign dc   = dc_sum[10:3];
    assign a4   = m3_s4[10:3];
    assign a3   = m3_s3[9:2];
    assign a5   = m3_s5[9:2];
    assign v4a5 = m4_s5[9:2];
    assign v4a4 = m4_s4[9:2];
    assign m5x0 = m5_s0[10:3];
    assign m5x1 = m5_s1[9:2];
    assign m6x0 = m6_s0[10:3];
    assign m7x0 = m7_s0[10:3];
    assign m7x1 = m7_s1[9:2];
    assign m9a4 = m9_s4[10:3];
    assign m9a5 = m9_s5[10:3];

    always_comb
    begin
        ok = 1'b0;
        for (int y = 0; y < 4; y++)
        begin
            for (int x = 0; x < 4; x++)
            begin
                b[y][x] = 8'd0;
            end
        end
        unique case (mode_t'(req.mode))
            MODE_DC:
            begin
                if (ht && hl)
                begin
                    ok = 1'b1;
                    for (int y = 0; y < 4; y++)
                    begin
                        for (int x = 0; x < 4; x++)
                        begin
                            b[y][x] = dc;
                        end
                    end
                end
            end
            MODE_VERT:
            begin
                if (ht)
                begin
                    ok = 1'b1;
                    for (int y = 0; y < 4; y++)
                    begin
                        for (int x = 0; x < 4; x++)
                        begin
                            b[y][x] = t[x];
                        end
                    end
                end
            end
            MODE_HORIZ:
            begin
                if (hl)
                begin
                    ok = 1'b1;
                    for (int y = 0; y < 4; y++)
                    begin
                        for (int x = 0; x < 4; x++)
                        begin
                            b[y][x] = l[y];
                        end
                    end
                end
            end
            MODE_DIAG_TR:
            begin
                if (ht && htr)
                begin
                    ok = 1'b1;
                    b[0][0] = t[1]; b[0][1] = t[2]; b[0][2] = a3;   b[0][3] = a4;
                    b[1][0] = t[2]; b[1][1] = a3;   b[1][2] = a4;   b[1][3] = a5;
                    b[2][0] = a3;   b[2][1] = a4;   b[2][2] = a5;   b[2][3] = t[6];
                    b[3][0] = a4;   b[3][1] = a5;   b[3][2] = t[6]; b[3][3] = t[7];
                end
            end
            MODE_VERT_LEFT:
            begin
                if (ht && htr)
                begin
                    ok = 1'b1;
                    b[0][0] = avg2(t[0], t[1]);
                    b[0][1] = avg2(t[1], t[2]);
                    b[0][2] = avg2(t[2], t[3]);
                    b[0][3] = avg2(t[3], v4a4);
                    b[1][0] = t[1]; b[1][1] = t[2]; b[1][2] = t[3]; b[1][3] = v4a4;
                    b[2][0] = avg2(t[1], t[2]);
                    b[2][1] = avg2(t[2], t[3]);
                    b[2][2] = avg2(t[3], v4a4);
                    b[2][3] = avg2(v4a5, v4a4);
                    b[3][0] = t[2]; b[3][1] = t[3]; b[3][2] = v4a4; b[3][3] = v4a5;
                end
            end
            MODE_VERT_RGT:
            begin
                if (ht && hl)
                begin
                    ok = 1'b1;
                    b[0][0] = m5x1;
                    b[0][1] = avg2(t[0], t[1]);
                    b[0][2] = avg2(t[1], t[2]);
                    b[0][3] = avg2(t[2], t[3]);
                    b[1][0] = m5x0; b[1][1] = t[0]; b[1][2] = t[1]; b[1][3] = t[2];
                    b[2][0] = l[0];
                    b[2][1] = m5x1;
                    b[2][2] = avg2(t[0], t[1]);
                    b[2][3] = avg2(t[1], t[2]);
                    b[3][0] = l[1]; b[3][1] = m5x0; b[3][2] = t[0]; b[3][3] = t[1];
                end
            end
            MODE_DOWN_RGT:
            begin
                if (ht && hl)
                begin
                    ok = 1'b1;
                    b[0][0] = m6x0; b[0][1] = t[0]; b[0][2] = t[1]; b[0][3] = t[2];
                    b[1][0] = l[0]; b[1][1] = m6x0; b[1][2] = t[0]; b[1][3] = t[1];
                    b[2][0] = l[1]; b[2][1] = l[0]; b[2][2] = m6x0; b[2][3] = t[0];
                    b[3][0] = l[2]; b[3][1] = l[1]; b[3][2] = l[0]; b[3][3] = m6x0;
                end
            end
            MODE_HORIZ_DN:
            begin
                if (ht && hl)
                begin
                    ok = 1'b1;
                    b[0][0] = m7x1; b[0][1] = m7x0; b[0][2] = t[0]; b[0][3] = t[1];
                    b[1][0] = avg2(l[0], l[1]);
                    b[1][1] = l[0]; b[1][2] = m7x1; b[1][3] = m7x0;
                    b[2][0] = avg2(l[1], l[2]);
                    b[2][1] = l[1];
                    b[2][2] = avg2(l[0], l[1]);
                    b[2][3] = l[0];
                    b[3][0] = avg2(l[2], l[3]);
                    b[3][1] = l[2];
                    b[3][2] = avg2(l[1], l[2]);
                    b[3][3] = l[1];
                end
            end
            MODE_HORIZ_UP:
            begin
                if (hl)
                begin
                    ok = 1'b1;
                    b[0][0] = avg2(l[0], l[1]);
                    b[0][1] = l[1];
                    b[0][2] = avg2(l[1], l[2]);
                    b[0][3] = l[2];
                    b[1][0] = avg2(l[1], l[2]);
                    b[1][1] = l[2];
                    b[1][2] = avg2(l[2], l[3]);
                    b[1][3] = l[3];
                    b[2][0] = avg2(l[2], l[3]);
                    b[2][1] = l[3];
                    b[2][2] = avg2(l[3], l[4]);
                    b[2][3] = l[4];
                    b[3][0] = avg2(l[3], l[4]);
                    b[3][1] = l[4];
                    b[3][2] = avg2(l[4], l[5]);
                    b[3][3] = l[5];
                end
            end
            MODE_DIAG_BL:
            begin
                if (hl)
                begin
                    ok = 1'b1;
                    b[0][0] = l[1]; b[0][1] = l[2]; b[0][2] = l[3]; b[0][3] = m9a4;
                    b[1][0] = l[2]; b[1][1] = l[3]; b[1][2] = m9a4; b[1][3] = m9a5;
                    b[2][0] = l[3]; b[2][1] = m9a4; b[2][2] = m9a5; b[2][3] = l[6];
                    b[3][0] = m9a4; b[3][1] = m9a5; b[3][2] = l[6]; b[3][3] = l[7];
                end
            end
            MODE_FLAT:
            begin
                ok = 1'b1;
                for (int y = 0; y < 4; y++)
                begin
                    for (int x = 0; x < 4; x++)
                    begin
                        b[y][x] = FLAT_LEVEL;
                    end
                end
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        res.usable = ok;
        for (int y = 0; y < 4; y++)
        begin
            res.rows[y] = {b[y][3], b[y][2], b[y][1], b[y][0]};
        end
    end

endmodule

`default_nettype wire

/* rtl/core/intra_4x4_block_predictor.sv */
// Top level of the 4x4 intra block predictor: input register, datapath, result register.
// Depends on iap_pkg and iap_predict.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------------
//  in      | in_valid / in_stall  | mode, have_*, top/left/corner/far pixels
//  out     | out_valid / out_stall| mode_usable, row_zero .. row_three
//
// One item per cycle sustained while out_stall is low; an item passes the input register, then the result register.
// The prediction datapath sits between the two registers and sets the clock period.
// Reset clears only the two stage valid flags; no clearing pass.
// A stalled result holds in the result register while one more item waits in the
// input register; in_stall rises only when both are full and out_stall is high.
`timescale 1ns / 1ps
`default_nettype none

module intra_4x4_block_predictor
    import iap_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [3:0]  mode,
    input  wire logic        have_top,
    input  wire logic        have_left,
    input  wire logic        have_below_left,
    input  wire logic        have_top_right,
    input  wire logic [63:0] top_pixels,
    input  wire logic [63:0] left_pixels,
    input  wire logic [7:0]  corner_pixel,
    input  wire logic [23:0] far_above_right,
    input  wire logic [7:0]  far_above_corner,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             mode_usable,
    output logic [31:0]      row_zero,
    output logic [31:0]      row_one,
    output logic [31:0]      row_two,
    output logic [31:0]      row_three
);

    logic      s1_valid_reg, s1_valid_next;
    logic      out_valid_reg, out_valid_next;
    pred_req_t req_reg, req_next;
    pred_res_t res_reg, res_next;
    logic      s2_ready;
    logic      s1_load;

    assign s2_ready = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !s2_ready;
    assign s1_load  = in_valid && !in_stall;

    always_comb
    begin
        req_next.mode       = mode;
        req_next.avail      = (have_top        ? AVAIL_TOP        : 4'd0)
                            | (have_left       ? AVAIL_LEFT       : 4'd0)
                            | (have_below_left ? AVAIL_BELOW_LEFT : 4'd0)
                            | (have_top_right  ? AVAIL_TOP_RIGHT  : 4'd0);
        req_next.top        = top_pixels;
        req_next.left       = left_pixels;
        req_next.corner     = corner_pixel;
        req_next.far_right  = far_above_right;
        req_next.far_corner = far_above_corner;
    end

    iap_predict u_predict
    (
        .req (req_reg),
        .res (res_next)
    );

    always_comb
    begin
        s1_valid_next  = in_stall ? s1_valid_reg : in_valid;
        out_valid_next = s2_ready ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            req_reg <= req_next;
        end
        if (s1_valid_reg && s2_ready)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign mode_usable = res_reg.usable;
    assign row_zero    = res_reg.rows[0];
    assign row_one     = res_reg.rows[1];
    assign row_two     = res_reg.rows[2];
    assign row_three   = res_reg.rows[3];

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled while pipeline has room");

    a_stage_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !(out_valid_reg && out_stall)) |=> out_valid_reg)
        else $error("item in input register was lost");

    a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> s1_valid_reg)
        else $error("accepted item not held in input register");

    a_unusable_rows_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !mode_usable) |->
            (row_zero == 32'd0 && row_one == 32'd0 && row_two == 32'd0 && row_three == 32'd0))
        else $error("unusable mode produced nonzero rows");
`endif

endmodule

`default_nettype wire
